// ----- rtl/rotated_rect_aperture_mask_macros.svh -----
// assertion helpers for the aperture mask
`ifndef ROTATED_RECT_APERTURE_MASK_MACROS_SVH
`define ROTATED_RECT_APERTURE_MASK_MACROS_SVH

// consequent checked in the same cycle
`define RRAM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rram: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define RRAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rram: next-cycle check failed");

`endif

// ----- rtl/rram_pkg.sv -----
package rram_pkg;

    localparam int MAX_GRID_DEF    = 1024;
    localparam int COORD_FRAC_BITS = 16;
    localparam int TRIG_FRAC_BITS  = 16;
    localparam int TRIG_W          = 18;
    localparam int LEN_W           = 31;
    localparam int SHIFT_W         = 32;
    localparam int SAMPLE_W        = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WIDTH_X    = 3'd0,
        REG_WIDTH_Y    = 3'd1,
        REG_SHIFT_X    = 3'd2,
        REG_SHIFT_Y    = 3'd3,
        REG_COS_ROT    = 3'd4,
        REG_SIN_ROT    = 3'd5,
        REG_PIXEL_STEP = 3'd6,
        REG_GRID_N     = 3'd7
    } t_reg_idx;

    localparam logic [LEN_W-1:0]          WIDTH_RESET = {LEN_W{1'b1}};
    localparam logic signed [TRIG_W-1:0]  COS_RESET   = TRIG_W'(1 << TRIG_FRAC_BITS);
    localparam logic [LEN_W-1:0]          STEP_RESET  = LEN_W'(1 << COORD_FRAC_BITS);

endpackage

// ----- rtl/rotated_rect_aperture_mask.sv -----
// Rotated rectangular aperture mask. Each input beat carries one complex field sample
// with its x/y grid indices; the point is placed at (index - grid_n/2) * pixel_step -
// shift, rotated by the cos/sin registers, and the sample is zeroed (and flagged in
// tuser) when either rotated coordinate lies beyond half the aperture side; a point on
// the edge passes. All arithmetic is exact. The datapath is six register stages
// (index multiply, shift subtract, split rotation products, product merge, rotated sum,
// edge compare with output register), so a beat is taken every cycle while the output is
// not stalled; the stage enables chain back from the output in the same cycle, so a
// stalled output holds only the full stages behind it and any bubble upstream still
// fills. Registers are to be written only while the pipeline is empty.
module rotated_rect_aperture_mask #(
    parameter int MAX_GRID = rram_pkg::MAX_GRID_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rram_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [rram_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // x_index, y_index, in_real, in_imag, zero pad
    input  logic [((2*$clog2(MAX_GRID)+2*rram_pkg::SAMPLE_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_real, out_imag
    output logic [2*rram_pkg::SAMPLE_W-1:0]        m_axis_tdata,
    // blocked
    output logic                                   m_axis_tuser
);

    localparam int IDX_W  = $clog2(MAX_GRID);
    localparam int GRID_W = IDX_W + 1;
    localparam int SW     = rram_pkg::SAMPLE_W;
    localparam int TW     = rram_pkg::TRIG_W;
    localparam int P_W    = IDX_W + 1 + rram_pkg::LEN_W + 1;
    localparam int X0_W   = P_W + 1;
    localparam int LO_W   = X0_W / 2;
    localparam int HI_W   = X0_W - LO_W;
    localparam int PLO_W  = LO_W + 1 + TW;
    localparam int PHI_W  = HI_W + TW;
    localparam int M_W    = X0_W + TW;
    localparam int R_W    = M_W + 1;
    localparam int WID_W  = rram_pkg::LEN_W + rram_pkg::TRIG_FRAC_BITS + 1;
    localparam int C_W    = ((R_W + 1 > WID_W) ? R_W + 1 : WID_W) + 1;
    localparam int NSTG   = 6;

    // configuration
    logic [rram_pkg::LEN_W-1:0]          r_width_x, r_width_y, r_step;
    logic signed [rram_pkg::SHIFT_W-1:0] r_shift_x, r_shift_y;
    logic signed [TW-1:0]                r_cos, r_sin;
    logic [GRID_W-1:0]                   r_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_x <= rram_pkg::WIDTH_RESET;
            r_width_y <= rram_pkg::WIDTH_RESET;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_cos     <= rram_pkg::COS_RESET;
            r_sin     <= '0;
            r_step    <= rram_pkg::STEP_RESET;
            r_grid    <= GRID_W'(MAX_GRID);
        end else if (i_cfg_we) begin
            case (rram_pkg::t_reg_idx'(i_cfg_addr))
                rram_pkg::REG_WIDTH_X:    r_width_x <= i_cfg_data[rram_pkg::LEN_W-1:0];
                rram_pkg::REG_WIDTH_Y:    r_width_y <= i_cfg_data[rram_pkg::LEN_W-1:0];
                rram_pkg::REG_SHIFT_X:    r_shift_x <= i_cfg_data[rram_pkg::SHIFT_W-1:0];
                rram_pkg::REG_SHIFT_Y:    r_shift_y <= i_cfg_data[rram_pkg::SHIFT_W-1:0];
                rram_pkg::REG_COS_ROT:    r_cos     <= i_cfg_data[TW-1:0];
                rram_pkg::REG_SIN_ROT:    r_sin     <= i_cfg_data[TW-1:0];
                rram_pkg::REG_PIXEL_STEP: r_step    <= i_cfg_data[rram_pkg::LEN_W-1:0];
                rram_pkg::REG_GRID_N:     r_grid    <= i_cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];

    // sample carried alongside
    logic signed [SW-1:0] r_re [NSTG-1];
    logic signed [SW-1:0] r_im [NSTG-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_re[0] <= s_axis_tdata[2*IDX_W+SW-1:2*IDX_W];
            r_im[0] <= s_axis_tdata[2*IDX_W+2*SW-1:2*IDX_W+SW];
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (en[k]) begin
                r_re[k] <= r_re[k-1];
                r_im[k] <= r_im[k-1];
            end
        end
    end

    // stage 0: centred index times pixel step
    logic signed [IDX_W:0]  n_xi, n_yi;
    logic signed [P_W-1:0]  n_px, n_py, r_px, r_py;

    always_comb begin
        n_xi = $signed({1'b0, s_axis_tdata[IDX_W-1:0]}) - $signed({1'b0, r_grid[GRID_W-1:1]});
        n_yi = $signed({1'b0, s_axis_tdata[2*IDX_W-1:IDX_W]})
             - $signed({1'b0, r_grid[GRID_W-1:1]});
        n_px = n_xi * $signed({1'b0, r_step});
        n_py = n_yi * $signed({1'b0, r_step});
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    // stage 1: aperture shift
    logic signed [X0_W-1:0] r_x0, r_y0;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_x0 <= r_px - r_shift_x;
            r_y0 <= r_py - r_shift_y;
        end
    end

    // stage 2: split rotation products
    logic signed [PLO_W-1:0] r_xc_lo, r_xs_lo, r_yc_lo, r_ys_lo;
    logic signed [PHI_W-1:0] r_xc_hi, r_xs_hi, r_yc_hi, r_ys_hi;
    logic signed [LO_W:0]    x_lo, y_lo;
    logic signed [HI_W-1:0]  x_hi, y_hi;

    always_comb begin
        x_lo = $signed({1'b0, r_x0[LO_W-1:0]});
        y_lo = $signed({1'b0, r_y0[LO_W-1:0]});
        x_hi = r_x0[X0_W-1:LO_W];
        y_hi = r_y0[X0_W-1:LO_W];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_xc_lo <= x_lo * r_cos;
            r_xs_lo <= x_lo * r_sin;
            r_yc_lo <= y_lo * r_cos;
            r_ys_lo <= y_lo * r_sin;
            r_xc_hi <= x_hi * r_cos;
            r_xs_hi <= x_hi * r_sin;
            r_yc_hi <= y_hi * r_cos;
            r_ys_hi <= y_hi * r_sin;
        end
    end

    // stage 3: merge halves
    logic signed [M_W-1:0] r_xc, r_xs, r_yc, r_ys;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_xc <= $signed({r_xc_hi, {LO_W{1'b0}}}) + r_xc_lo;
            r_xs <= $signed({r_xs_hi, {LO_W{1'b0}}}) + r_xs_lo;
            r_yc <= $signed({r_yc_hi, {LO_W{1'b0}}}) + r_yc_lo;
            r_ys <= $signed({r_ys_hi, {LO_W{1'b0}}}) + r_ys_lo;
        end
    end

    // stage 4: rotated coordinates
    logic signed [R_W-1:0] r_xr, r_yr;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_xr <= r_xc + r_ys;
            r_yr <= r_yc - r_xs;
        end
    end

    // stage 5: edge compare, 2|r| against side in rotated format
    logic signed [C_W-1:0] c_xr, c_yr, c_wx, c_wy;
    logic                  n_blk;
    logic signed [SW-1:0]  r_out_re, r_out_im;
    logic                  r_out_blk;

    always_comb begin
        c_xr  = $signed({r_xr, 1'b0});
        c_yr  = $signed({r_yr, 1'b0});
        c_wx  = $signed({1'b0, r_width_x, {rram_pkg::TRIG_FRAC_BITS{1'b0}}});
        c_wy  = $signed({1'b0, r_width_y, {rram_pkg::TRIG_FRAC_BITS{1'b0}}});
        n_blk = (c_xr > c_wx) || (c_xr < -c_wx) || (c_yr > c_wy) || (c_yr < -c_wy);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_out_re  <= n_blk ? '0 : r_re[NSTG-2];
            r_out_im  <= n_blk ? '0 : r_im[NSTG-2];
            r_out_blk <= n_blk;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tuser  = r_out_blk;

endmodule

// ----- rtl/rram_chk.sv -----
`include "rotated_rect_aperture_mask_macros.svh"

module rram_chk #(
    parameter int MAX_GRID = rram_pkg::MAX_GRID_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [((2*$clog2(MAX_GRID)+2*rram_pkg::SAMPLE_W+7)/8)*8-1:0] s_axis_tdata,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [2*rram_pkg::SAMPLE_W-1:0]        m_axis_tdata,
    input logic                                   m_axis_tuser
);

    // a held result beat keeps its contents
    `RRAM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a blocked beat carries a zero sample
    `RRAM_ASSERT_SAME(a_blk_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

    // input back-pressure only comes from a stalled output
    `RRAM_ASSERT_SAME(a_ready_src, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind rotated_rect_aperture_mask rram_chk #(.MAX_GRID(MAX_GRID)) u_rram_chk (.*);
